// ===== hdl/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants of the reverse-Polish stack evaluator.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // token classes
  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_SUB     = 3'd2,
    CMD_MUL     = 3'd3,
    CMD_UNKNOWN = 3'd4,
    CMD_FINISH  = 3'd5
  } cmd_e;

  // finish status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FAILED    = 2'd1,
    ST_NOT_EMPTY = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // what a stack cell loads this cycle
  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_ABOVE = 2'd1,
    CM_BELOW = 2'd2
  } cell_mode_e;

  // controller state
  typedef enum logic {
    S_IDLE = 1'b0,
    S_MUL  = 1'b1
  } state_e;

  // one stack entry: not-a-number mark and Q16.16 value
  typedef struct packed {
    logic                     invalid;
    logic signed [DATA_W-1:0] value;
  } entry_t;

endpackage

// ===== hdl/rse_cell.sv =====
// ----------------------------------------------------------------------------
// rse_cell
// One stack cell: holds an entry, or takes the entry of the cell above
// (push) or below (pop).
// ----------------------------------------------------------------------------
module rse_cell
  import rse_pkg::*;
(
  input  logic       clk_i,
  input  cell_mode_e mode_i,
  input  entry_t     above_i,
  input  entry_t     below_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // select the next entry
  always_comb begin
    case (mode_i)
      CM_ABOVE: entry_d = above_i;
      CM_BELOW: entry_d = below_i;
      default:  entry_d = entry_q;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hdl/rse_mul.sv =====
// ----------------------------------------------------------------------------
// rse_mul
// Fixed-point multiplier: registered 64-bit product, then round to nearest
// (ties up) at the binary point and saturate to 32 bits.
// ----------------------------------------------------------------------------
module rse_mul
  import rse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic signed [DATA_W-1:0] res_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam logic signed [PROD_W-1:0] HALF = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] scaled;
  logic                     fits;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  // round, shift down and saturate; arithmetic shift floors both signs
  always_comb begin
    rounded = prod_q + HALF;
    scaled  = rounded >>> FRAC_BITS;
    fits    = (&scaled[PROD_W-1:DATA_W-1]) || ~(|scaled[PROD_W-1:DATA_W-1]);
    if (fits) begin
      res_o = scaled[DATA_W-1:0];
    end else if (scaled[PROD_W-1]) begin
      res_o = MIN_VAL;
    end else begin
      res_o = MAX_VAL;
    end
  end

endmodule

// ===== hdl/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse-Polish evaluator on signed Q16.16 words over a shifting stack.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Numbers are pushed,
// add/subtract/multiply pop two entries and push the saturated result, and
// finish pops the result and clears the stack. The stack is a row of cells
// that shift as a whole, so a word updates the stack when taken, except a
// multiply on two valid operands, which pushes its result from S_MUL (busy
// is high there) because the product is registered before rounding.
// The only result word, produced for finish, shows on result_valid_o for
// exactly one cycle the cycle after finish is taken, and it cannot be held
// off. A finish reports not-empty if entries lie under the result, else
// overflow, else failed; result_value_o is zero unless the status is ok.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator
  import rse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               command_i,
  input  logic signed [DATA_W-1:0] operand_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic [1:0]               status_o
);

  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     ovf_q, ovf_d;
  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  status_e                  status_q, status_d;

  entry_t                   cell_ent [STACK_DEPTH];
  entry_t                   new_top;
  logic                     do_push, do_pop;
  logic                     accept;
  logic                     has1, has2, bad_x, bad_y;
  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W-1:0] arith;
  logic signed [DATA_W-1:0] mul_res;
  entry_t                   x_ent, y_ent;
  cmd_e                     cmd;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q == S_MUL);
  assign cmd    = cmd_e'(command_i);
  assign x_ent  = cell_ent[0];
  assign y_ent  = cell_ent[1];
  assign has1   = (count_q != '0);
  assign has2   = (count_q > CNT_W'(1));
  assign bad_x  = !has1 || x_ent.invalid;
  assign bad_y  = !has2 || y_ent.invalid;

  // add or subtract (second minus top) with saturation
  always_comb begin
    if (cmd == CMD_ADD) begin
      sum = {y_ent.value[DATA_W-1], y_ent.value} + {x_ent.value[DATA_W-1], x_ent.value};
    end else begin
      sum = {y_ent.value[DATA_W-1], y_ent.value} - {x_ent.value[DATA_W-1], x_ent.value};
    end
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      arith = sum[DATA_W] ? MIN_VAL : MAX_VAL;
    end else begin
      arith = sum[DATA_W-1:0];
    end
  end

  // multiplier, product registered when a multiply word is taken
  rse_mul u_mul (
    .clk_i (clk_i),
    .en_i  (accept && (cmd == CMD_MUL)),
    .a_i   (x_ent.value),
    .b_i   (y_ent.value),
    .res_o (mul_res)
  );

  // next state and stack control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    valid_d  = 1'b0;
    value_d  = value_q;
    status_d = status_q;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    new_top  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH: begin
              if (count_q == DEPTH_CNT) begin
                ovf_d = 1'b1;
              end else begin
                do_push = 1'b1;
                new_top = entry_t'{invalid: 1'b0, value: operand_i};
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
              if ((cmd == CMD_MUL) && !bad_x && !bad_y) begin
                state_d = S_MUL;
              end else begin
                do_pop  = 1'b1;
                new_top = (bad_x || bad_y) ? entry_t'{invalid: 1'b1, value: '0}
                                           : entry_t'{invalid: 1'b0, value: arith};
                count_d = has2 ? (count_q - CNT_W'(1)) : CNT_W'(1);
              end
            end
            CMD_FINISH: begin
              valid_d = 1'b1;
              if (has2) begin
                status_d = ST_NOT_EMPTY;
              end else if (ovf_q) begin
                status_d = ST_OVERFLOW;
              end else if (bad_x) begin
                status_d = ST_FAILED;
              end else begin
                status_d = ST_OK;
              end
              value_d = (!has2 && !ovf_q && !bad_x) ? x_ent.value : '0;
              count_d = '0;
              ovf_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        do_pop  = 1'b1;
        new_top = entry_t'{invalid: 1'b0, value: mul_res};
        count_d = count_q - CNT_W'(1);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // chain of stack cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_mode_e mode;
    entry_t     above, below;
    always_comb begin
      if (do_push) begin
        mode = CM_ABOVE;
      end else if (do_pop) begin
        mode = (i == 0) ? CM_ABOVE : CM_BELOW;
      end else begin
        mode = CM_HOLD;
      end
    end
    if (i == 0) begin : g_top
      assign above = new_top;
    end else begin : g_mid
      assign above = cell_ent[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign below = '0;
    end else begin : g_body
      assign below = cell_ent[i+1];
    end
    rse_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_ent[i])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  // result word registers
  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign result_valid_o = valid_q;
  assign result_value_o = value_q;
  assign status_o       = status_q;

`ifndef NO_ASSERTIONS
  // multiply holds busy for one cycle only
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |=> !busy)
    else $error("busy held more than one cycle");

  // stack never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DEPTH_CNT)
    else $error("stack count beyond depth");

  // a result word follows a taken finish word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (command_i == CMD_FINISH) |=> result_valid_o)
    else $error("finish word without result");

  // finish leaves an empty stack and a cleared overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (count_q == '0) && !ovf_q)
    else $error("stack not cleared at finish");

  // a failing status carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_OK) |-> (result_value_o == '0))
    else $error("nonzero value with failing status");
`endif

endmodule
